FILE: hdl/quaternion_to_euler_defines.svh
// Assertion macros used by the checker file of the quaternion to Euler block
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define Q2E_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e check failed");

// next-cycle implication
`define Q2E_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e check failed");

`endif

FILE: hdl/q2e_pkg.sv
// Types, constants and the arctangent table of the quaternion to Euler block
package q2e_pkg;

	localparam int OPW = 34;            // Q6.28 operand width into the atan2 units
	localparam int CXW = 36;            // CORDIC vector width, covers gain growth
	localparam int ACW = 20;            // CORDIC angle accumulator, Q16 radians
	localparam int CORDIC_STAGES = 16;
	localparam int RT_STEPS = 29;       // one root bit per step, 58-bit radicand
	localparam int RT_NW = 2 * RT_STEPS;
	localparam int RT_RW = RT_STEPS + 2;
	localparam int OPS_LAST = 4 + RT_STEPS;              // stage where the root is ready
	localparam int ANG_LAST = OPS_LAST + CORDIC_STAGES + 2;
	localparam int PIPE_DEPTH = ANG_LAST + 1;

	localparam logic signed [OPW-1:0] ONE_Q28 = OPW'(64'sd268435456);
	localparam logic signed [ACW-1:0] HALF_PI_Q16 = ACW'(102944);
	localparam int PI_Q13 = 25736;
	localparam int TWO_PI_Q13 = 51472;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_item_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] yaw_angle;
		logic               roll_out_of_domain;
	} euler_item_t;

	function automatic logic signed [ACW-1:0] atan_entry(input logic [3:0] idx);
		logic signed [ACW-1:0] v;
		unique case (idx)
			4'd0:  v = ACW'(51472);
			4'd1:  v = ACW'(30386);
			4'd2:  v = ACW'(16055);
			4'd3:  v = ACW'(8150);
			4'd4:  v = ACW'(4091);
			4'd5:  v = ACW'(2047);
			4'd6:  v = ACW'(1024);
			4'd7:  v = ACW'(512);
			4'd8:  v = ACW'(256);
			4'd9:  v = ACW'(128);
			4'd10: v = ACW'(64);
			4'd11: v = ACW'(32);
			4'd12: v = ACW'(16);
			4'd13: v = ACW'(8);
			4'd14: v = ACW'(4);
			4'd15: v = ACW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/quaternion_to_euler.sv
// Top level: quaternion (Q2.14) to pitch, roll, yaw (Q3.13 radians) pipeline
// Usage:
//   Input channel quat_valid / quat_ready / quat carries one quaternion per item.
//   Output channel euler_valid / euler_ready / euler carries the three angles
//   and the roll out-of-domain flag, one result item per input item, in order.
// Stages, in order, from acceptance to euler_valid:
//   1 product stage, 1 sum stage, 1 squaring stage, 1 radicand stage,
//   29 square-root steps (one root bit each), the CORDIC stages, 1 output stage.
// Throughput: one item per cycle while not stalled; each stage has a valid bit.
// Stall: the whole pipe advances on one enable; while euler_valid is high and
//   euler_ready is low nothing moves and quat_ready is low. The held result
//   stays unchanged until taken; quat_ready comes back the cycle it is taken.
// Reset: arst_n clears all valid bits at once; the pipe comes up empty and
//   quat_ready is high right after reset.
module quaternion_to_euler (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  quat_valid,
	output logic                  quat_ready,
	input  q2e_pkg::quat_item_t   quat,
	output logic                  euler_valid,
	input  logic                  euler_ready,
	output q2e_pkg::euler_item_t  euler
);

	localparam int OPW   = q2e_pkg::OPW;
	localparam int NSTP  = q2e_pkg::RT_STEPS;
	localparam int NW    = q2e_pkg::RT_NW;
	localparam int RW    = q2e_pkg::RT_RW;
	localparam int OLAST = q2e_pkg::OPS_LAST;
	localparam int ALAST = q2e_pkg::ANG_LAST;
	localparam int DEPTH = q2e_pkg::PIPE_DEPTH;

	typedef struct packed {
		logic signed [31:0] xz, wy, xy, zw, yy, zz, ww, xw, yz;
	} prod_t;

	typedef struct packed {
		logic signed [OPW-1:0] a;
		logic signed [OPW-1:0] yaw_y;
		logic signed [OPW-1:0] yaw_x;
		logic signed [OPW-1:0] pit_y;
		logic signed [OPW-1:0] pit_x;
	} ops_t;

	logic en;
	logic vld_s [1:DEPTH];
	prod_t prod_s1;
	ops_t  op_s [2:OLAST];
	logic  fl_s [2:ALAST];
	logic [NSTP-1:0] mag_s2;
	logic [NW-1:0]   sq_s3;
	logic [NW-2:0]   rem_s4;
	logic [NW-1:0]   rt_n_s  [0:NSTP-1];
	logic [RW-1:0]   rt_rm_s [0:NSTP-1];
	logic [NSTP-1:0] rt_q_s  [0:NSTP-1];
	q2e_pkg::euler_item_t euler_s52;

	prod_t prod_d;
	ops_t  op_d;
	logic signed [OPW-1:0] a_abs;
	logic [NW-1:0]   n_in  [0:NSTP-1];
	logic [RW-1:0]   rm_in [0:NSTP-1];
	logic [NSTP-1:0] q_in  [0:NSTP-1];
	logic [NW-1:0]   n_nx  [0:NSTP-1];
	logic [RW-1:0]   rm_nx [0:NSTP-1];
	logic [NSTP-1:0] q_nx  [0:NSTP-1];
	logic [RW+1:0]   tr, tt;
	logic signed [15:0] ang_p, ang_r, ang_y;
	logic signed [16:0] pd;
	q2e_pkg::euler_item_t euler_d;

	assign en = !vld_s[DEPTH] || euler_ready;
	assign quat_ready = en;
	assign euler_valid = vld_s[DEPTH];
	assign euler = euler_s52;

	always_comb begin
		prod_d.xz = quat.quat_x * quat.quat_z;
		prod_d.wy = quat.quat_w * quat.quat_y;
		prod_d.xy = quat.quat_x * quat.quat_y;
		prod_d.zw = quat.quat_z * quat.quat_w;
		prod_d.yy = quat.quat_y * quat.quat_y;
		prod_d.zz = quat.quat_z * quat.quat_z;
		prod_d.ww = quat.quat_w * quat.quat_w;
		prod_d.xw = quat.quat_x * quat.quat_w;
		prod_d.yz = quat.quat_y * quat.quat_z;
	end

	always_comb begin
		op_d.a     = (OPW'(prod_s1.xz) - OPW'(prod_s1.wy)) <<< 1;
		op_d.yaw_y = (OPW'(prod_s1.xy) + OPW'(prod_s1.zw)) <<< 1;
		op_d.yaw_x = q2e_pkg::ONE_Q28 - ((OPW'(prod_s1.yy) + OPW'(prod_s1.zz)) <<< 1);
		op_d.pit_y = (OPW'(prod_s1.xw) + OPW'(prod_s1.yz)) <<< 1;
		op_d.pit_x = q2e_pkg::ONE_Q28 - ((OPW'(prod_s1.zz) + OPW'(prod_s1.ww)) <<< 1);
		a_abs = (op_d.a < 0) ? -op_d.a : op_d.a;
	end

	// floor square root, restoring, two radicand bits per step
	always_comb begin
		tr = '0;
		tt = '0;
		for (int j = 0; j < NSTP; j++) begin
			if (j == 0) begin
				n_in[j]  = {1'b0, rem_s4};
				rm_in[j] = '0;
				q_in[j]  = '0;
			end else begin
				n_in[j]  = rt_n_s[j-1];
				rm_in[j] = rt_rm_s[j-1];
				q_in[j]  = rt_q_s[j-1];
			end
			tr = {rm_in[j], n_in[j][NW-1 -: 2]};
			tt = {2'b00, q_in[j], 2'b01};
			n_nx[j] = n_in[j] << 2;
			if (tr >= tt) begin
				rm_nx[j] = RW'(tr - tt);
				q_nx[j]  = {q_in[j][NSTP-2:0], 1'b1};
			end else begin
				rm_nx[j] = RW'(tr);
				q_nx[j]  = {q_in[j][NSTP-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DEPTH; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= quat_valid;
			for (int k = 2; k <= DEPTH; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			op_s[2] <= op_d;
			fl_s[2] <= a_abs > q2e_pkg::ONE_Q28;
			mag_s2  <= a_abs[NSTP-1:0];
			for (int k = 3; k <= OLAST; k++)
				op_s[k] <= op_s[k-1];
			for (int k = 3; k <= ALAST; k++)
				fl_s[k] <= fl_s[k-1];
			sq_s3  <= mag_s2 * mag_s2;
			rem_s4 <= ((NW-1)'(1) << (NW-2)) - sq_s3[NW-2:0];
			for (int j = 0; j < NSTP; j++) begin
				rt_n_s[j]  <= n_nx[j];
				rt_rm_s[j] <= rm_nx[j];
				rt_q_s[j]  <= q_nx[j];
			end
			euler_s52 <= euler_d;
		end
	end

	q2e_cordic u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (op_s[OLAST].a),
		.x_in  ($signed(OPW'(rt_q_s[NSTP-1]))),
		.angle (ang_r)
	);

	q2e_cordic u_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (op_s[OLAST].yaw_y),
		.x_in  (op_s[OLAST].yaw_x),
		.angle (ang_y)
	);

	q2e_cordic u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (op_s[OLAST].pit_y),
		.x_in  (op_s[OLAST].pit_x),
		.angle (ang_p)
	);

	always_comb begin
		pd = 17'(q2e_pkg::PI_Q13) - 17'(ang_p);
		if (pd > 17'(q2e_pkg::PI_Q13))
			pd = pd - 17'(q2e_pkg::TWO_PI_Q13);
		euler_d.pitch_angle        = pd[15:0];
		euler_d.roll_angle         = fl_s[ALAST] ? 16'sd0 : -ang_r;
		euler_d.yaw_angle          = ang_y;
		euler_d.roll_out_of_domain = fl_s[ALAST];
	end

endmodule

FILE: hdl/q2e_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q13 radians, stalls on en
module q2e_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [q2e_pkg::OPW-1:0]    y_in,
	input  logic signed [q2e_pkg::OPW-1:0]    x_in,
	output logic signed [15:0]                angle
);

	localparam int CXW = q2e_pkg::CXW;
	localparam int ACW = q2e_pkg::ACW;
	localparam int NS  = q2e_pkg::CORDIC_STAGES;

	logic signed [CXW-1:0] cx_s  [0:NS];
	logic signed [CXW-1:0] cy_s  [0:NS];
	logic signed [ACW-1:0] acc_s [0:NS];
	logic                  zero_s [0:NS];
	logic signed [15:0]    angle_q;

	logic signed [CXW-1:0] xe, ye, px, py, xs, ys;
	logic signed [ACW-1:0] pa, rnd;
	logic signed [ACW-4:0] rv, sat;
	logic signed [CXW-1:0] nx [0:NS-1];
	logic signed [CXW-1:0] ny [0:NS-1];
	logic signed [ACW-1:0] na [0:NS-1];

	always_comb begin
		xe = CXW'(x_in);
		ye = CXW'(y_in);
		// left half plane: quarter turn first
		if (xe < 0) begin
			if (ye >= 0) begin
				px = ye;
				py = -xe;
				pa = q2e_pkg::HALF_PI_Q16;
			end else begin
				px = -ye;
				py = xe;
				pa = -q2e_pkg::HALF_PI_Q16;
			end
		end else begin
			px = xe;
			py = ye;
			pa = '0;
		end
		xs = '0;
		ys = '0;
		for (int i = 0; i < NS; i++) begin
			xs = cx_s[i] >>> i;
			ys = cy_s[i] >>> i;
			if (cy_s[i] >= 0) begin
				nx[i] = cx_s[i] + ys;
				ny[i] = cy_s[i] - xs;
				na[i] = acc_s[i] + q2e_pkg::atan_entry(4'(i));
			end else begin
				nx[i] = cx_s[i] - ys;
				ny[i] = cy_s[i] + xs;
				na[i] = acc_s[i] - q2e_pkg::atan_entry(4'(i));
			end
		end
		rnd = acc_s[NS] + ACW'(4);
		rv  = $signed(rnd[ACW-1:3]);
		if (rv > (ACW-3)'(q2e_pkg::PI_Q13))
			sat = (ACW-3)'(q2e_pkg::PI_Q13);
		else if (rv < -((ACW-3)'(q2e_pkg::PI_Q13)))
			sat = -((ACW-3)'(q2e_pkg::PI_Q13));
		else
			sat = rv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]   <= px;
			cy_s[0]   <= py;
			acc_s[0]  <= pa;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			for (int i = 0; i < NS; i++) begin
				cx_s[i+1]   <= nx[i];
				cy_s[i+1]   <= ny[i];
				acc_s[i+1]  <= na[i];
				zero_s[i+1] <= zero_s[i];
			end
			angle_q <= zero_s[NS] ? 16'sd0 : 16'(sat);
		end
	end

	assign angle = angle_q;

endmodule

FILE: hdl/q2e_checker.sv
// Port-level checker for the quaternion to Euler block, bound to the top level
`include "quaternion_to_euler_defines.svh"

module q2e_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  quat_ready,
	input logic                  euler_valid,
	input logic                  euler_ready,
	input q2e_pkg::euler_item_t  euler
);

	// a held result keeps its value
	`Q2E_ASSERT_NXT(a_hold, euler_valid && !euler_ready, euler_valid && $stable(euler))
	// a stalled output freezes intake
	`Q2E_ASSERT_IMP(a_stall, euler_valid && !euler_ready, !quat_ready)
	// an empty output slot always takes input
	`Q2E_ASSERT_IMP(a_open, !euler_valid, quat_ready)
	// out-of-domain roll is forced to zero
	`Q2E_ASSERT_IMP(a_roll, euler_valid && euler.roll_out_of_domain, euler.roll_angle == 16'sd0)
	// pitch stays wrapped into [-pi, pi]
	`Q2E_ASSERT_IMP(a_pitch, euler_valid,
		euler.pitch_angle <= 16'sd25736 && euler.pitch_angle >= -16'sd25736)

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.quat_ready  (quat_ready),
	.euler_valid (euler_valid),
	.euler_ready (euler_ready),
	.euler       (euler)
);
